[rtl/core/hslpa_pkg.sv]
`timescale 1ns / 1ps

package hslpa_pkg;

  // register indexes on paddr[3:2]
  localparam logic [1:0] RegHue        = 2'd0;
  localparam logic [1:0] RegSaturation = 2'd1;
  localparam logic [1:0] RegLightness  = 2'd2;

  localparam int unsigned DivSteps = 9;

  // floor(x / 51) for x = 10 * sum: sum * 205610 >> 20, just above 2^20 * 10 / 51
  localparam logic [17:0] LightRecip = 18'd205610;
  // floor(w / 625) for w < 2^18: w * ceil(2^28 / 625) >> 28
  localparam logic [18:0] OutRecip   = 19'd429497;

  typedef enum logic [2:0] {
    HUE_GRAY,
    HUE_RED_UP,
    HUE_RED_WRAP,
    HUE_GREEN,
    HUE_BLUE
  } hue_case_e;

  typedef enum logic [2:0] {
    SEC_0,
    SEC_60,
    SEC_120,
    SEC_180,
    SEC_240,
    SEC_300
  } sector_e;

  // shared pipeline control: valid of the stage and the global advance
  typedef struct packed {
    logic valid;
    logic adv;
  } pipe_ctl_t;

endpackage

[rtl/core/hslpa_fwd.sv]
`timescale 1ns / 1ps

module hslpa_fwd (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hslpa_pkg::pipe_ctl_t ctl_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output logic                valid_o,
  output logic [16:0]         hue_num_o,
  output logic [7:0]          hue_div_o,
  output logic [16:0]         sat_num_o,
  output logic [7:0]          sat_div_o,
  output logic [6:0]          light_o
);

  // stage 1: extremes and case
  logic                 v1_q;
  logic [7:0]           d_q;
  logic [8:0]           sum_q;
  logic signed [8:0]    diff_q;
  hslpa_pkg::hue_case_e case_q;

  logic [7:0]           mx, mn;
  logic signed [8:0]    diff_d;
  hslpa_pkg::hue_case_e case_d;
  logic                 rmax, gmax;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    rmax = (mx == red_i);
    gmax = !rmax && (mx == green_i);
    if (mx == mn) begin
      case_d = hslpa_pkg::HUE_GRAY;
      diff_d = 9'sd0;
    end else if (rmax) begin
      if (green_i >= blue_i) begin
        case_d = hslpa_pkg::HUE_RED_UP;
        diff_d = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
      end else begin
        case_d = hslpa_pkg::HUE_RED_WRAP;
        diff_d = $signed({1'b0, blue_i}) - $signed({1'b0, green_i});
      end
    end else if (gmax) begin
      case_d = hslpa_pkg::HUE_GREEN;
      diff_d = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      case_d = hslpa_pkg::HUE_BLUE;
      diff_d = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ctl_i.adv) begin
      v1_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      d_q    <= mx - mn;
      sum_q  <= {1'b0, mx} + {1'b0, mn};
      diff_q <= diff_d;
      case_q <= case_d;
    end
  end

  // stage 2: dividends, divisors, lightness
  logic signed [18:0] dx, dd, hn;
  logic [7:0]         den;
  logic [26:0]        lprod;
  logic [16:0]        hue_num_d;

  always_comb begin
    dx = {{10{diff_q[8]}}, diff_q};
    dd = $signed({11'b0, d_q});
    case (case_q)
      hslpa_pkg::HUE_RED_UP:   hn = 19'sd60 * dx;
      hslpa_pkg::HUE_RED_WRAP: hn = 19'sd360 * dd - 19'sd60 * dx;
      hslpa_pkg::HUE_GREEN:    hn = 19'sd60 * dx + 19'sd120 * dd;
      hslpa_pkg::HUE_BLUE:     hn = 19'sd60 * dx + 19'sd240 * dd;
      default:                 hn = 19'sd0;
    endcase
    hue_num_d = hn[16:0];
    if (sum_q <= 9'd255) den = sum_q[7:0];
    else den = 8'(10'd510 - {1'b0, sum_q});
    lprod = 27'(sum_q) * 27'(hslpa_pkg::LightRecip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (ctl_i.adv) begin
      valid_o <= v1_q;
    end
  end

  // gray pixels divide zero hue by one; a zero saturation divisor is forced to one
  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      hue_num_o <= hue_num_d;
      hue_div_o <= (d_q == 8'd0) ? 8'd1 : d_q;
      sat_num_o <= 17'(d_q) * 17'd100;
      sat_div_o <= (den == 8'd0) ? 8'd1 : den;
      light_o   <= lprod[26:20];
    end
  end

endmodule

[rtl/core/hslpa_div.sv]
`timescale 1ns / 1ps

module hslpa_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hslpa_pkg::pipe_ctl_t ctl_i,
  input  logic [16:0]         hue_num_i,
  input  logic [7:0]          hue_div_i,
  input  logic [16:0]         sat_num_i,
  input  logic [7:0]          sat_div_i,
  input  logic [6:0]          light_i,
  output logic                valid_o,
  output logic [8:0]          hue_o,
  output logic [6:0]          sat_o,
  output logic [6:0]          light_o
);

  localparam int unsigned N = hslpa_pkg::DivSteps;

  logic        v_q    [N];
  logic [16:0] hrem_q [N];
  logic [8:0]  hq_q   [N];
  logic [7:0]  hdv_q  [N];
  logic [16:0] srem_q [N];
  logic [8:0]  sq_q   [N];
  logic [7:0]  sdv_q  [N];
  logic [6:0]  l_q    [N];

  for (genvar j = 0; j < N; j++) begin : g_step
    logic        v_p;
    logic [16:0] hrem_p, srem_p, hsh, ssh;
    logic [8:0]  hq_p, sq_p;
    logic [7:0]  hdv_p, sdv_p;
    logic [6:0]  l_p;

    if (j == 0) begin : g_first
      always_comb begin
        v_p    = ctl_i.valid;
        hrem_p = hue_num_i;
        hq_p   = '0;
        hdv_p  = hue_div_i;
        srem_p = sat_num_i;
        sq_p   = '0;
        sdv_p  = sat_div_i;
        l_p    = light_i;
      end
    end else begin : g_next
      always_comb begin
        v_p    = v_q[j-1];
        hrem_p = hrem_q[j-1];
        hq_p   = hq_q[j-1];
        hdv_p  = hdv_q[j-1];
        srem_p = srem_q[j-1];
        sq_p   = sq_q[j-1];
        sdv_p  = sdv_q[j-1];
        l_p    = l_q[j-1];
      end
    end

    // one quotient bit per stage, most significant first
    assign hsh = 17'(hdv_p) << (N - 1 - j);
    assign ssh = 17'(sdv_p) << (N - 1 - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (ctl_i.adv) begin
        v_q[j] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        hdv_q[j] <= hdv_p;
        sdv_q[j] <= sdv_p;
        l_q[j]   <= l_p;
        if (hrem_p >= hsh) begin
          hrem_q[j] <= hrem_p - hsh;
          hq_q[j]   <= hq_p | (9'd1 << (N - 1 - j));
        end else begin
          hrem_q[j] <= hrem_p;
          hq_q[j]   <= hq_p;
        end
        if (srem_p >= ssh) begin
          srem_q[j] <= srem_p - ssh;
          sq_q[j]   <= sq_p | (9'd1 << (N - 1 - j));
        end else begin
          srem_q[j] <= srem_p;
          sq_q[j]   <= sq_p;
        end
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign hue_o   = hq_q[N-1];
  assign sat_o   = sq_q[N-1][6:0];
  assign light_o = l_q[N-1];

endmodule

[rtl/core/hslpa_inv.sv]
`timescale 1ns / 1ps

module hslpa_inv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hslpa_pkg::pipe_ctl_t ctl_i,
  input  logic [9:0]          hue_off_i,
  input  logic [7:0]          sat_off_i,
  input  logic [7:0]          light_off_i,
  input  logic [8:0]          hue_i,
  input  logic [6:0]          sat_i,
  input  logic [6:0]          light_i,
  output logic                valid_o,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o
);

  // stage A: offsets
  logic              va_q;
  logic [8:0]        ha_q;
  logic [6:0]        sa_q, la_q;
  logic signed [10:0] hs;
  logic signed [8:0]  ss, ls;
  logic [8:0]        ha_d;
  logic [6:0]        sa_d, la_d;

  always_comb begin
    hs = $signed({2'b0, hue_i}) + $signed({hue_off_i[9], hue_off_i});
    ss = $signed({2'b0, sat_i}) + $signed({sat_off_i[7], sat_off_i});
    ls = $signed({2'b0, light_i}) + $signed({light_off_i[7], light_off_i});
    // out of range hue drops to zero, no wrap
    if (hs < 11'sd0 || hs >= 11'sd360) ha_d = 9'd0;
    else ha_d = hs[8:0];
    if (ss < 9'sd0) sa_d = 7'd0;
    else if (ss > 9'sd100) sa_d = 7'd100;
    else sa_d = ss[6:0];
    if (ls < 9'sd0) la_d = 7'd0;
    else if (ls > 9'sd100) la_d = 7'd100;
    else la_d = ls[6:0];
  end

  // stage B: chroma numerator, ramp, sector
  logic                 vb_q;
  logic [13:0]          cn_q;
  logic [5:0]           k_q;
  logic [6:0]           lb_q;
  hslpa_pkg::sector_e   secb_q;
  logic [7:0]           t, hm;
  logic [6:0]           w;
  logic [5:0]           k_d;
  hslpa_pkg::sector_e   sec_d;

  always_comb begin
    t = (la_q >= 7'd50) ? 8'({la_q, 1'b0} - 8'd100) : 8'(8'd100 - {la_q, 1'b0});
    w = 7'(8'd100 - t);
    if (ha_q >= 9'd240) hm = 8'(ha_q - 9'd240);
    else if (ha_q >= 9'd120) hm = 8'(ha_q - 9'd120);
    else hm = ha_q[7:0];
    k_d = (hm >= 8'd60) ? 6'(8'd120 - hm) : hm[5:0];
    if (ha_q < 9'd60) sec_d = hslpa_pkg::SEC_0;
    else if (ha_q < 9'd120) sec_d = hslpa_pkg::SEC_60;
    else if (ha_q < 9'd180) sec_d = hslpa_pkg::SEC_120;
    else if (ha_q < 9'd240) sec_d = hslpa_pkg::SEC_180;
    else if (ha_q < 9'd300) sec_d = hslpa_pkg::SEC_240;
    else sec_d = hslpa_pkg::SEC_300;
  end

  // stage C: C, X and m, all over 600000
  logic                 vc_q;
  logic [19:0]          c_q, x_q, m_q;
  hslpa_pkg::sector_e   secc_q;
  logic [14:0]          lm;

  assign lm = 15'(15'(lb_q) * 15'd200 - 15'(cn_q));

  // stage D: per channel sum and first scale
  logic        vd_q;
  logic [19:0] wr_q, wg_q, wb_q;
  logic [19:0] pr, pg, pb;
  logic [25:0] zr, zg, zb;

  always_comb begin
    case (secc_q)
      hslpa_pkg::SEC_0:   begin pr = c_q;   pg = x_q;   pb = 20'd0; end
      hslpa_pkg::SEC_60:  begin pr = x_q;   pg = c_q;   pb = 20'd0; end
      hslpa_pkg::SEC_120: begin pr = 20'd0; pg = c_q;   pb = x_q;   end
      hslpa_pkg::SEC_180: begin pr = 20'd0; pg = x_q;   pb = c_q;   end
      hslpa_pkg::SEC_240: begin pr = x_q;   pg = 20'd0; pb = c_q;   end
      default:            begin pr = c_q;   pg = 20'd0; pb = x_q;   end
    endcase
    // 255 / 600000 = 17 / (64 * 625)
    zr = (26'(pr) + 26'(m_q)) * 26'd17;
    zg = (26'(pg) + 26'(m_q)) * 26'd17;
    zb = (26'(pb) + 26'(m_q)) * 26'd17;
  end

  // stage E: divide by 625 and clamp
  logic [38:0] qr, qg, qb;

  assign qr = 39'(wr_q) * 39'(hslpa_pkg::OutRecip);
  assign qg = 39'(wg_q) * 39'(hslpa_pkg::OutRecip);
  assign qb = 39'(wb_q) * 39'(hslpa_pkg::OutRecip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      vc_q    <= 1'b0;
      vd_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (ctl_i.adv) begin
      va_q    <= ctl_i.valid;
      vb_q    <= va_q;
      vc_q    <= vb_q;
      vd_q    <= vc_q;
      valid_o <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv) begin
      ha_q   <= ha_d;
      sa_q   <= sa_d;
      la_q   <= la_d;
      cn_q   <= 14'(w) * 14'(sa_q);
      k_q    <= k_d;
      lb_q   <= la_q;
      secb_q <= sec_d;
      c_q    <= 20'(cn_q) * 20'd60;
      x_q    <= 20'(cn_q) * 20'(k_q);
      m_q    <= 20'(lm) * 20'd30;
      secc_q <= secb_q;
      wr_q   <= zr[25:6];
      wg_q   <= zg[25:6];
      wb_q   <= zb[25:6];
      red_o   <= (qr[38:28] > 11'd255) ? 8'd255 : qr[35:28];
      green_o <= (qg[38:28] > 11'd255) ? 8'd255 : qg[35:28];
      blue_o  <= (qb[38:28] > 11'd255) ? 8'd255 : qb[35:28];
    end
  end

endmodule

[rtl/core/hsl_pixel_adjust.sv]
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// pixel in  input      in_valid_i / in_ready_o   red_in_i, green_in_i, blue_in_i
// pixel out output     out_valid_o / out_ready_i red_out_o, green_out_o, blue_out_o
// config    input      APB psel/penable/pwrite   hue, saturation, lightness offsets
//
// One pixel per cycle while the output is not stalled, through 16 register stages.
// Hue and saturation pass through the 9-stage restoring divider.
// Reset clears all valid bits and the offsets to zero.
// A stall on the output freezes the whole pipeline in place; nothing is lost.
module hsl_pixel_adjust (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o
);

  logic [9:0] hue_off_q;
  logic [7:0] sat_off_q, light_off_q;
  logic       adv;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_off_q   <= '0;
      sat_off_q   <= '0;
      light_off_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        hslpa_pkg::RegHue:        hue_off_q   <= pwdata[9:0];
        hslpa_pkg::RegSaturation: sat_off_q   <= pwdata[7:0];
        hslpa_pkg::RegLightness:  light_off_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      hslpa_pkg::RegHue:        prdata = {22'b0, hue_off_q};
      hslpa_pkg::RegSaturation: prdata = {24'b0, sat_off_q};
      hslpa_pkg::RegLightness:  prdata = {24'b0, light_off_q};
      default:                  prdata = '0;
    endcase
  end

  // advance everything while the output register is empty or being taken
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  hslpa_pkg::pipe_ctl_t ctl_in, ctl_div, ctl_inv;
  logic        fwd_valid, div_valid;
  logic [16:0] hue_num, sat_num;
  logic [7:0]  hue_dv, sat_dv;
  logic [6:0]  light_f, light_d, sat_q7;
  logic [8:0]  hue_q9;

  assign ctl_in  = '{valid: in_valid_i, adv: adv};
  assign ctl_div = '{valid: fwd_valid, adv: adv};
  assign ctl_inv = '{valid: div_valid, adv: adv};

  hslpa_fwd u_fwd (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_in),
    .red_i     (red_in_i),
    .green_i   (green_in_i),
    .blue_i    (blue_in_i),
    .valid_o   (fwd_valid),
    .hue_num_o (hue_num),
    .hue_div_o (hue_dv),
    .sat_num_o (sat_num),
    .sat_div_o (sat_dv),
    .light_o   (light_f)
  );

  hslpa_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl_div),
    .hue_num_i (hue_num),
    .hue_div_i (hue_dv),
    .sat_num_i (sat_num),
    .sat_div_i (sat_dv),
    .light_i   (light_f),
    .valid_o   (div_valid),
    .hue_o     (hue_q9),
    .sat_o     (sat_q7),
    .light_o   (light_d)
  );

  hslpa_inv u_inv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl_inv),
    .hue_off_i   (hue_off_q),
    .sat_off_i   (sat_off_q),
    .light_off_i (light_off_q),
    .hue_i       (hue_q9),
    .sat_i       (sat_q7),
    .light_i     (light_d),
    .valid_o     (out_valid_o),
    .red_o       (red_out_o),
    .green_o     (green_out_o),
    .blue_o      (blue_out_o)
  );

endmodule

[bench/hsl_pixel_adjust_tb.sv]
`timescale 1ns / 1ps

module hsl_pixel_adjust_tb;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  red_in_i;
  logic [7:0]  green_in_i;
  logic [7:0]  blue_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;

  hsl_pixel_adjust u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o)
  );

  int   hue_ofs;
  int   sat_ofs;
  int   light_ofs;
  rgb_t expected_pixels[$];
  int   mismatch_count;
  int   pixels_sent;
  int   pixels_checked;
  bit   sink_stalls_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int clamp_range(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] to_channel(longint p, longint m);
    longint v;
    v = ((p + m) * 255) / 600000;
    return 8'(clamp_range(int'(v), 0, 255));
  endfunction

  function automatic rgb_t adjust_pixel(rgb_t px);
    int r, g, b, mx, mn, d, sum, h, s, l, den, dbl;
    longint cn, k, c, x, m, pr, pg, pb;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    sum = mx + mn;
    if (d == 0) h = 0;
    else if (mx == r) h = (g < b) ? (360 * d - 60 * (b - g)) / d : (60 * (g - b)) / d;
    else if (mx == g) h = (60 * (b - r) + 120 * d) / d;
    else h = (60 * (r - g) + 240 * d) / d;
    l = (10 * sum) / 51;
    if (d == 0) s = 0;
    else begin
      den = (sum <= 255) ? sum : 510 - sum;
      s = (100 * d) / den;
    end
    h = h + hue_ofs;
    if (h < 0 || h >= 360) h = 0;
    s = clamp_range(s + sat_ofs, 0, 100);
    l = clamp_range(l + light_ofs, 0, 100);
    dbl = 2 * l - 100;
    if (dbl < 0) dbl = -dbl;
    cn = longint'(100 - dbl) * s;
    k = (h % 120) - 60;
    if (k < 0) k = -k;
    k = 60 - k;
    c = 60 * cn;
    x = cn * k;
    m = 30 * (200 * longint'(l) - cn);
    pr = 0;
    pg = 0;
    pb = 0;
    if (h < 60) begin pr = c; pg = x; end
    else if (h < 120) begin pr = x; pg = c; end
    else if (h < 180) begin pg = c; pb = x; end
    else if (h < 240) begin pg = x; pb = c; end
    else if (h < 300) begin pr = x; pb = c; end
    else begin pr = c; pb = x; end
    adjust_pixel.red   = to_channel(pr, m);
    adjust_pixel.green = to_channel(pg, m);
    adjust_pixel.blue  = to_channel(pb, m);
  endfunction

  // scoreboard plus random backpressure on the output
  initial begin
    int stall;
    rgb_t exp_px;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 18);
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        pixels_checked++;
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected transfer: %0d %0d %0d", red_out_o, green_out_o, blue_out_o);
        end else begin
          exp_px = expected_pixels.pop_front();
          if (exp_px.red !== red_out_o || exp_px.green !== green_out_o
              || exp_px.blue !== blue_out_o) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("pixel mismatch: exp %0d %0d %0d got %0d %0d %0d",
                       exp_px.red, exp_px.green, exp_px.blue,
                       red_out_o, green_out_o, blue_out_o);
          end
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain_pipe();
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_offsets(int hue, int sat, int light);
    drain_pipe();
    write_reg(hslpa_pkg::RegHue, hue);
    write_reg(hslpa_pkg::RegSaturation, sat);
    write_reg(hslpa_pkg::RegLightness, light);
    hue_ofs   = hue;
    sat_ofs   = sat;
    light_ofs = light;
  endtask

  task automatic send_pixel(rgb_t px, bit gaps);
    if (gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i   <= px.red;
    green_in_i <= px.green;
    blue_in_i  <= px.blue;
    do @(posedge clk_i); while (!in_ready_o);
    expected_pixels.push_back(adjust_pixel(px));
    pixels_sent++;
  endtask

  task automatic end_burst();
    in_valid_i <= 1'b0;
  endtask

  function automatic rgb_t rand_pixel();
    rgb_t px;
    px = rgb_t'($urandom);
    // bias toward gray and tie cases now and then
    case ($urandom_range(0, 7))
      0: begin px.green = px.red; px.blue = px.red; end
      1: px.green = px.red;
      2: px.blue = px.green;
      default: ;
    endcase
    return px;
  endfunction

  task automatic test_directed();
    rgb_t corners[$];
    corners = '{{8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255}, {8'd128, 8'd128, 8'd128},
                {8'd255, 8'd0, 8'd0}, {8'd0, 8'd255, 8'd0}, {8'd0, 8'd0, 8'd255},
                {8'd255, 8'd255, 8'd0}, {8'd0, 8'd255, 8'd255}, {8'd255, 8'd0, 8'd255},
                {8'd255, 8'd0, 8'd1}, {8'd200, 8'd10, 8'd100}, {8'd10, 8'd200, 8'd50},
                {8'd30, 8'd60, 8'd240}, {8'd170, 8'd85, 8'd85}, {8'd1, 8'd0, 8'd0},
                {8'd254, 8'd255, 8'd255}, {8'd100, 8'd100, 8'd50}, {8'd85, 8'd170, 8'd170}};
    foreach (corners[i]) send_pixel(corners[i], 1'b0);
    end_burst();
  endtask

  task automatic test_offset_extremes();
    rgb_t px;
    int settings[6][3] = '{'{360, 100, 100}, '{-360, -100, -100}, '{359, 0, 0},
                           '{-1, 50, -50}, '{180, -100, 100}, '{1, 100, -100}};
    foreach (settings[i]) begin
      set_offsets(settings[i][0], settings[i][1], settings[i][2]);
      for (int n = 0; n < 20; n++) begin
        px = rand_pixel();
        send_pixel(px, 1'b1);
      end
      end_burst();
    end
  endtask

  task automatic test_random_offsets();
    for (int phase = 0; phase < 10; phase++) begin
      set_offsets($urandom_range(0, 720) - 360, $urandom_range(0, 200) - 100,
                  $urandom_range(0, 200) - 100);
      for (int n = 0; n < 100; n++) send_pixel(rand_pixel(), 1'b1);
      end_burst();
    end
  endtask

  // last part: full rate on both sides
  task automatic test_full_rate();
    set_offsets($urandom_range(0, 720) - 360, $urandom_range(0, 200) - 100,
                $urandom_range(0, 200) - 100);
    sink_stalls_on = 1'b0;
    for (int n = 0; n < 300; n++) send_pixel(rand_pixel(), 1'b0);
    end_burst();
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    red_in_i = '0;
    green_in_i = '0;
    blue_in_i = '0;
    hue_ofs = 0;
    sat_ofs = 0;
    light_ofs = 0;
    sink_stalls_on = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_offset_extremes();
    test_random_offsets();
    test_full_rate();
    drain_pipe();
    repeat (30) @(posedge clk_i);
    $display("covered %0d pixels over 18 offset settings, %0d transfers checked",
             pixels_sent, pixels_checked);
    if (mismatch_count == 0 && expected_pixels.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[hsl_pixel_adjust.f]
rtl/core/hslpa_pkg.sv
rtl/core/hslpa_fwd.sv
rtl/core/hslpa_div.sv
rtl/core/hslpa_inv.sv
rtl/core/hsl_pixel_adjust.sv
bench/hsl_pixel_adjust_tb.sv
